>>> design/npc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest point correspondence unit.
// -----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned DistBits  = 50;
  localparam int unsigned CountBits = 11;
  localparam int unsigned SlotBits  = 10;
  localparam int unsigned CoarseBits = 16;

  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};
  localparam logic [DistBits-1:0] TolReset = DistBits'(43);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_MATCH = 1'b1
  } cmd_e;

  localparam logic CfgFineCount = 1'b0;
  localparam logic CfgTolerance = 1'b1;

  // token handed from one search cell to the next
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [SlotBits-1:0] idx;
  } cell_ctl_t;

endpackage

>>> design/npc_dist_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// npc_dist_cell
// One cell of the distance chain: squares one coordinate difference and adds
// it to the partial sum handed in from the previous cell, saturating.
// -----------------------------------------------------------------------------
module npc_dist_cell import npc_pkg::*; #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_ctl_t                    ctl_i,
  input  logic [DistBits-1:0]          sum_i,
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output cell_ctl_t                    ctl_o,
  output logic [DistBits-1:0]          sum_o
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned SqBits   = 2 * COORD_BITS;
  localparam int unsigned AccBits  = (SqBits > DistBits ? SqBits : DistBits) + 1;

  logic signed [DiffBits-1:0] diff;
  logic [COORD_BITS-1:0]      mag;
  logic [SqBits-1:0]          sq;
  logic [AccBits-1:0]         acc;
  logic [DistBits-1:0]        sum_d;
  cell_ctl_t                  ctl_q;
  logic [DistBits-1:0]        sum_q;

  always_comb begin
    diff = DiffBits'(a_i) - DiffBits'(b_i);
    mag  = diff[DiffBits-1] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
    // the magnitude of a COORD_BITS+1 difference can need COORD_BITS+1 bits
    sq   = (diff[DiffBits-1] && (COORD_BITS'(-diff) == '0) && diff != '0)
           ? SqBits'({1'b1, {COORD_BITS{1'b0}}}) * SqBits'({1'b1, {COORD_BITS{1'b0}}})
           : SqBits'(mag) * SqBits'(mag);
    acc  = AccBits'(sq) + AccBits'(sum_i);
    sum_d = (acc > AccBits'(DistMax)) ? DistMax : DistBits'(acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign ctl_o = ctl_q;
  assign sum_o = sum_q;

endmodule

>>> design/npc_min_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// npc_min_cell
// Last cell of the chain: keeps the running minimum and its index.
// -----------------------------------------------------------------------------
module npc_min_cell import npc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                first_i,
  input  cell_ctl_t           ctl_i,
  input  logic [DistBits-1:0] sum_i,
  output logic                done_o,
  output logic                seen_o,
  output logic [SlotBits-1:0] best_idx_o,
  output logic [DistBits-1:0] best_dist_o
);

  logic                seen_q;
  logic                done_q;
  logic [SlotBits-1:0] idx_q;
  logic [DistBits-1:0] dist_q;
  logic                take;

  // strict less keeps the lowest index on ties
  assign take = ctl_i.valid && (!seen_q || first_i || sum_i < dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid && ctl_i.last;
      if (ctl_i.valid) begin
        seen_q <= 1'b1;
      end else if (first_i) begin
        seen_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q  <= ctl_i.idx;
      dist_q <= sum_i;
    end
  end

  assign done_o      = done_q;
  assign seen_o      = seen_q;
  assign best_idx_o  = idx_q;
  assign best_dist_o = dist_q;

endmodule

>>> design/nearest_point_correspondence_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nearest_point_correspondence_unit
// Brute-force 3D nearest neighbor search over a loaded table of fine points.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// command   in         start_i & !busy_o         command_i, fine_slot_i, ...
// result    out        valid_o (one cycle)       matched_coarse_o ... min_dist_sq_o
// config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// After reset the claimed marks are cleared one entry per cycle while busy_o
// stays high. A load never raises busy_o. A match streams n = min(fine_count,
// FINE_DEPTH) table entries, one per cycle, through three distance cells and a
// minimum cell; busy_o drops in the cycle its result appears, and the next
// transaction can be accepted in that same cycle.
// The receiver cannot stall results.
// -----------------------------------------------------------------------------
module nearest_point_correspondence_unit import npc_pkg::*; #(
  parameter int unsigned FINE_DEPTH = 1024,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         command_i,
  input  logic [SlotBits-1:0]          fine_slot_i,
  input  logic [CoarseBits-1:0]        coarse_index_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [DistBits-1:0]          cfg_data_i,
  output logic                         valid_o,
  output logic [CoarseBits-1:0]        matched_coarse_o,
  output logic [SlotBits-1:0]          nearest_fine_o,
  output logic                         found_o,
  output logic                         too_far_o,
  output logic                         duplicate_o,
  output logic [DistBits-1:0]          min_dist_sq_o
);

  localparam int unsigned AddrBits = $clog2(FINE_DEPTH);
  localparam int unsigned NBits    = $clog2(FINE_DEPTH + 1);
  localparam int unsigned CntBits  = (NBits > CountBits) ? NBits : CountBits;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [CountBits-1:0] fine_count_q;
  logic [DistBits-1:0]  tol_q;

  logic signed [COORD_BITS-1:0] mem_x [FINE_DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [FINE_DEPTH];
  logic signed [COORD_BITS-1:0] mem_z [FINE_DEPTH];
  logic                         claimed_mem [FINE_DEPTH];
  logic                         claim_rd_q;
  logic                         claim_we;
  logic                         claim_wdata;
  logic [AddrBits-1:0]          claim_waddr;
  logic [AddrBits-1:0]          clr_addr_q;

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z, fy_q, fz_q, fz2_q;
  logic [CoarseBits-1:0]        coarse_q;
  logic [NBits-1:0]             n_q;
  logic [NBits-1:0]             addr_q;
  logic                         first_q;
  cell_ctl_t                    rd_ctl_q;
  cell_ctl_t                    c1_ctl, c2_ctl, c3_ctl;
  logic [DistBits-1:0]          s1, s2, s3;
  logic                         done, seen;
  logic [SlotBits-1:0]          best_idx;
  logic [DistBits-1:0]          best_dist;
  logic [CntBits-1:0]           cnt_ext;
  logic [NBits-1:0]             n_sat;
  logic                         accept;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);
  assign cnt_ext = CntBits'(fine_count_q);
  assign n_sat   = (cnt_ext > CntBits'(FINE_DEPTH)) ? NBits'(FINE_DEPTH) : NBits'(cnt_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_count_q <= '0;
      tol_q        <= TolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFineCount: fine_count_q <= cfg_data_i[CountBits-1:0];
        CfgTolerance: tol_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CMD_LOAD && 32'(fine_slot_i) < FINE_DEPTH) begin
      mem_x[AddrBits'(fine_slot_i)] <= pos_x_i;
      mem_y[AddrBits'(fine_slot_i)] <= pos_y_i;
      mem_z[AddrBits'(fine_slot_i)] <= pos_z_i;
    end
    rd_x <= mem_x[addr_q[AddrBits-1:0]];
    rd_y <= mem_y[addr_q[AddrBits-1:0]];
    rd_z <= mem_z[addr_q[AddrBits-1:0]];
    // align later coordinates with their cell
    fy_q  <= rd_y;
    fz_q  <= rd_z;
    fz2_q <= fz_q;
  end

  // claimed marks: cleared after reset, cleared by a load, set by a match
  always_comb begin
    claim_we    = 1'b0;
    claim_waddr = clr_addr_q;
    claim_wdata = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        claim_we = 1'b1;
      end
      ST_IDLE: begin
        claim_we    = accept && command_i == CMD_LOAD && 32'(fine_slot_i) < FINE_DEPTH;
        claim_waddr = AddrBits'(fine_slot_i);
      end
      ST_FINISH: begin
        claim_we    = seen && (n_q != '0);
        claim_waddr = AddrBits'(best_idx);
        claim_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  // the winner is final once done is seen, so this read is ready in finish
  always_ff @(posedge clk_i) begin
    if (claim_we) begin
      claimed_mem[claim_waddr] <= claim_wdata;
    end
    claim_rd_q <= claimed_mem[AddrBits'(best_idx)];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      coarse_q <= coarse_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      addr_q     <= '0;
      n_q        <= '0;
      first_q    <= 1'b0;
      rd_ctl_q   <= '0;
      valid_o    <= 1'b0;
      matched_coarse_o <= '0;
      nearest_fine_o   <= '0;
      found_o          <= 1'b0;
      too_far_o        <= 1'b0;
      duplicate_o      <= 1'b0;
      min_dist_sq_o    <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          valid_o    <= 1'b0;
          first_q    <= 1'b0;
          rd_ctl_q   <= '0;
          clr_addr_q <= clr_addr_q + AddrBits'(1);
          if (clr_addr_q == AddrBits'(FINE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          valid_o  <= 1'b0;
          rd_ctl_q <= '0;
          first_q  <= accept && (command_i == CMD_MATCH);
          if (accept && command_i == CMD_MATCH) begin
            addr_q  <= '0;
            n_q     <= n_sat;
            state_q <= (n_sat == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          valid_o  <= 1'b0;
          first_q  <= 1'b0;
          rd_ctl_q <= '{valid: 1'b1,
                        last:  (addr_q + NBits'(1) == n_q),
                        idx:   SlotBits'(addr_q)};
          addr_q <= addr_q + NBits'(1);
          if (addr_q + NBits'(1) == n_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          valid_o  <= 1'b0;
          first_q  <= 1'b0;
          rd_ctl_q <= '0;
          if (done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          valid_o          <= 1'b1;
          first_q          <= 1'b0;
          rd_ctl_q         <= '0;
          matched_coarse_o <= coarse_q;
          found_o          <= seen && (n_q != '0);
          if (seen && n_q != '0) begin
            nearest_fine_o <= best_idx;
            min_dist_sq_o  <= best_dist;
            too_far_o      <= best_dist > tol_q;
            duplicate_o    <= claim_rd_q;
          end else begin
            nearest_fine_o <= '0;
            min_dist_sq_o  <= '0;
            too_far_o      <= 1'b0;
            duplicate_o    <= 1'b0;
          end
          n_q     <= '0;
          state_q <= ST_IDLE;
        end
        default: begin
          valid_o  <= 1'b0;
          first_q  <= 1'b0;
          rd_ctl_q <= '0;
          state_q  <= ST_IDLE;
        end
      endcase
    end
  end

  // rd_ctl_q and rd_x both describe the entry read at the same edge
  npc_dist_cell #(.COORD_BITS(COORD_BITS)) u_cell_x (
    .clk_i, .rst_ni, .ctl_i(rd_ctl_q), .sum_i('0), .a_i(px_q), .b_i(rd_x),
    .ctl_o(c1_ctl), .sum_o(s1)
  );
  npc_dist_cell #(.COORD_BITS(COORD_BITS)) u_cell_y (
    .clk_i, .rst_ni, .ctl_i(c1_ctl), .sum_i(s1), .a_i(py_q), .b_i(fy_q),
    .ctl_o(c2_ctl), .sum_o(s2)
  );
  npc_dist_cell #(.COORD_BITS(COORD_BITS)) u_cell_z (
    .clk_i, .rst_ni, .ctl_i(c2_ctl), .sum_i(s2), .a_i(pz_q), .b_i(fz2_q),
    .ctl_o(c3_ctl), .sum_o(s3)
  );

  npc_min_cell u_min (
    .clk_i, .rst_ni, .first_i(first_q), .ctl_i(c3_ctl), .sum_i(s3),
    .done_o(done), .seen_o(seen), .best_idx_o(best_idx), .best_dist_o(best_dist)
  );

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == ST_IDLE)) else $error("result outside idle");
  a_quiet_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !valid_o)
    else $error("result during clearing pass");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (min_dist_sq_o == '0 && !duplicate_o))
    else $error("empty search fields");

endmodule
